FILE: hdl/ihds_pkg.sv
// Shared types and constants for the image header dimension sniffer.
`timescale 1ns / 1ps

package ihds_pkg;

  localparam logic [7:0] BytePad    = 8'hFF;
  localparam logic [7:0] ByteSoi    = 8'hD8;
  localparam logic [7:0] ByteSof0   = 8'hC0;
  localparam logic [7:0] ByteSof1   = 8'hC1;
  localparam logic [7:0] ByteSof2   = 8'hC2;
  localparam logic [7:0] ByteSos    = 8'hDA;
  localparam logic [7:0] ByteEoi    = 8'hD9;
  localparam logic [7:0] BytePngSig0 = 8'h89;
  localparam logic [7:0] BytePngSig1 = 8'h50;
  localparam logic [7:0] BytePngSig2 = 8'h4E;
  localparam logic [7:0] BytePngSig3 = 8'h47;

  localparam logic [4:0] PngBodyStart = 5'd4;
  localparam logic [4:0] PngWidthLo   = 5'd16;
  localparam logic [4:0] PngWidthHi   = 5'd19;
  localparam logic [4:0] PngHeightLo  = 5'd20;
  localparam logic [4:0] PngHeightHi  = 5'd23;

  typedef enum logic [3:0] {
    ST_START = 4'd0,
    ST_JSIG  = 4'd1,
    ST_PSIG  = 4'd2,
    ST_SCAN  = 4'd3,
    ST_MARK  = 4'd4,
    ST_LENHI = 4'd5,
    ST_LENLO = 4'd6,
    ST_SKIP  = 4'd7,
    ST_SOF   = 4'd8,
    ST_PBODY = 4'd9,
    ST_DONE  = 4'd10
  } parse_state_e;

  typedef enum logic [1:0] {
    FMT_UNKNOWN = 2'd0,
    FMT_JPEG    = 2'd1,
    FMT_PNG     = 2'd2
  } format_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        found;
    format_e     format;
    logic [31:0] width;
    logic [31:0] height;
  } result_t;

endpackage

FILE: hdl/ihds_in_stage.sv
// Input register stage that holds one incoming word until the parser takes it.
`timescale 1ns / 1ps

module ihds_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ihds_pkg::in_word_t word_i,
  input  logic              take_i,
  output logic              valid_o,
  output ihds_pkg::in_word_t word_o
);
  import ihds_pkg::*;

  logic     valid_q, valid_d;
  in_word_t word_q;
  logic     accept;

  assign in_stall_o = valid_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign valid_d    = accept | (valid_q & ~take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

FILE: hdl/ihds_parser.sv
// Marker and signature parser that updates the header state once per word.
`timescale 1ns / 1ps

module ihds_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  ihds_pkg::in_word_t word_i,
  output ihds_pkg::result_t  result_o
);
  import ihds_pkg::*;

  parse_state_e state_q, state_d;
  logic [4:0]   pos_q, pos_d;
  logic [15:0]  skip_q, skip_d;
  logic [31:0]  width_q, width_d;
  logic [31:0]  height_q, height_d;
  format_e      format_q, format_d;
  logic         found_q, found_d;
  logic [7:0]   b;
  logic [15:0]  seg_len;
  logic [15:0]  seg_rem;
  logic [7:0]   png_want;

  assign b       = word_i.data_byte;
  assign seg_len = skip_q | {8'h00, b};
  assign seg_rem = (seg_len >= 16'd2) ? (seg_len - 16'd2) : 16'd0;

  always_comb begin
    unique case (pos_q)
      5'd1:    png_want = BytePngSig1;
      5'd2:    png_want = BytePngSig2;
      default: png_want = BytePngSig3;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    skip_d   = skip_q;
    width_d  = width_q;
    height_d = height_q;
    format_d = format_q;
    found_d  = found_q;
    unique case (state_q)
      ST_START: begin
        if (b == BytePad) begin
          state_d = ST_JSIG;
        end else if (b == BytePngSig0) begin
          state_d = ST_PSIG;
          pos_d   = 5'd1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_JSIG: begin
        if (b == ByteSoi) begin
          format_d = FMT_JPEG;
          state_d  = ST_SCAN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_PSIG: begin
        if (b != png_want) begin
          state_d = ST_DONE;
        end else if (pos_q == 5'd3) begin
          format_d = FMT_PNG;
          state_d  = ST_PBODY;
          pos_d    = PngBodyStart;
        end else begin
          pos_d = pos_q + 5'd1;
        end
      end
      ST_SCAN: begin
        if (b == BytePad) begin
          state_d = ST_MARK;
        end
      end
      ST_MARK: begin
        priority if (b == BytePad) begin
          state_d = ST_MARK;
        end else if (b == ByteSof0 || b == ByteSof1 || b == ByteSof2) begin
          state_d = ST_SOF;
          pos_d   = 5'd0;
        end else if (b == ByteSos || b == ByteEoi) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_LENHI;
        end
      end
      ST_LENHI: begin
        skip_d  = {b, 8'h00};
        state_d = ST_LENLO;
      end
      ST_LENLO: begin
        skip_d  = seg_rem;
        state_d = (seg_rem == 16'd0) ? ST_SCAN : ST_SKIP;
      end
      ST_SKIP: begin
        skip_d = skip_q - 16'd1;
        if (skip_q == 16'd1) begin
          state_d = ST_SCAN;
        end
      end
      ST_SOF: begin
        unique case (pos_q)
          5'd3:    height_d = {16'h0000, b, 8'h00};
          5'd4:    height_d = height_q | {24'h000000, b};
          5'd5:    width_d  = {16'h0000, b, 8'h00};
          5'd6: begin
            width_d = width_q | {24'h000000, b};
            found_d = 1'b1;
            state_d = ST_DONE;
          end
          default: ;
        endcase
        pos_d = pos_q + 5'd1;
      end
      ST_PBODY: begin
        if (pos_q >= PngWidthLo && pos_q <= PngWidthHi) begin
          width_d = {width_q[23:0], b};
        end else if (pos_q >= PngHeightLo && pos_q <= PngHeightHi) begin
          height_d = {height_q[23:0], b};
        end
        if (pos_q == PngHeightHi) begin
          found_d = 1'b1;
          state_d = ST_DONE;
        end
        pos_d = pos_q + 5'd1;
      end
      default: begin
        state_d = ST_DONE;
      end
    endcase
  end

  assign result_o.found  = found_d;
  assign result_o.format = format_d;
  assign result_o.width  = found_d ? width_d : 32'd0;
  assign result_o.height = found_d ? height_d : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_START;
      pos_q    <= 5'd0;
      skip_q   <= 16'd0;
      width_q  <= 32'd0;
      height_q <= 32'd0;
      format_q <= FMT_UNKNOWN;
      found_q  <= 1'b0;
    end else if (take_i) begin
      if (word_i.last_byte) begin
        state_q  <= ST_START;
        pos_q    <= 5'd0;
        skip_q   <= 16'd0;
        width_q  <= 32'd0;
        height_q <= 32'd0;
        format_q <= FMT_UNKNOWN;
        found_q  <= 1'b0;
      end else begin
        state_q  <= state_d;
        pos_q    <= pos_d;
        skip_q   <= skip_d;
        width_q  <= width_d;
        height_q <= height_d;
        format_q <= format_d;
        found_q  <= found_d;
      end
    end
  end

  // A find always ends the search for the rest of the file.
  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> state_q == ST_DONE)
    else $error("found set outside the done state");

  // A segment skip never sits on an exhausted count.
  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SKIP |-> skip_q != 16'd0)
    else $error("skip state with zero count");

  // The PNG body walk stays within the header bytes.
  a_pbody_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PBODY |-> (pos_q >= PngBodyStart && pos_q <= PngHeightHi
                             && format_q == FMT_PNG))
    else $error("PNG body position out of range");

  // A JPEG walk always follows a detected JPEG signature.
  a_jpeg_format: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_MARK || state_q == ST_SOF)
    |-> format_q == FMT_JPEG)
    else $error("JPEG scan without JPEG format");

endmodule

FILE: hdl/ihds_out_stage.sv
// Result register that holds one result word until the receiver takes it.
`timescale 1ns / 1ps

module ihds_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ihds_pkg::result_t result_i,
  output logic              busy_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ihds_pkg::result_t result_o
);
  import ihds_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign busy_o  = valid_q & out_stall_i;
  assign valid_d = load_i | busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

FILE: hdl/image_header_dimension_sniffer_unit.sv
// Top level of the image header dimension sniffer.
`timescale 1ns / 1ps
// The input channel carries an image file, one byte per word, with last_byte_i
// high on the final byte. A word is taken at a clock edge where in_valid_i is
// high and in_stall_o is low. Files that open with FF D8 are walked as JPEG
// marker chains; files that open with 89 50 4E 47 are read as PNG headers.
// For each file exactly one result word leaves on the output channel after
// its final byte: found_o, format_o (0 unknown, 1 JPEG, 2 PNG), and width_o
// and height_o, which are zero when nothing was found. A result is taken at
// an edge where out_valid_o is high and out_stall_i is low.
// Throughput is one byte per cycle except while a final byte waits for a stalled
// receiver. A byte is held in the input register and is parsed into the result
// register when the parser takes it; the result waits there for the receiver.
// While the receiver stalls, the result holds and bytes that give no result
// keep flowing; only a final byte waits in the input register, which then
// raises in_stall_o. Reset empties both registers and returns the parser to
// the start of a file.

module image_header_dimension_sniffer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [1:0]  format_o,
  output logic [31:0] width_o,
  output logic [31:0] height_o
);
  import ihds_pkg::*;

  in_word_t in_word;
  in_word_t held_word;
  logic     held_valid;
  logic     take;
  logic     out_busy;
  result_t  parse_result;
  result_t  out_result;

  assign in_word.data_byte = data_byte_i;
  assign in_word.last_byte = last_byte_i;

  assign take = held_valid & (~held_word.last_byte | ~out_busy);

  ihds_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .word_i     (in_word),
    .take_i     (take),
    .valid_o    (held_valid),
    .word_o     (held_word)
  );

  ihds_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .word_i   (held_word),
    .result_o (parse_result)
  );

  ihds_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take & held_word.last_byte),
    .result_i    (parse_result),
    .busy_o      (out_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign found_o  = out_result.found;
  assign format_o = out_result.format;
  assign width_o  = out_result.width;
  assign height_o = out_result.height;

endmodule
